>>> design/lbps_pkg.sv
`default_nettype none

package lbps_pkg;

  localparam int unsigned NumPatterns = 8;
  localparam int unsigned PatW        = 40;
  localparam int unsigned PatIdxW     = $clog2(NumPatterns);
  localparam int unsigned NumPins     = 3;

  typedef logic [PatW-1:0]    pat_word_t;
  typedef logic [PatIdxW-1:0] pat_idx_t;
  typedef logic [NumPins-1:0] pins_t;

  localparam pat_word_t PatDefault [NumPatterns] = '{
    40'd50397441, 40'd50398465, 40'd67174660, 40'd83951874,
    40'd4278848001, 40'd4278848014, 40'd16855556, 40'd42983885319
  };

  // opcodes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // color/mode byte
  localparam logic [1:0] MODE_ALL  = 2'd0;
  localparam logic [1:0] MODE_EDGE = 2'd1;

  localparam logic [3:0] SEL_STOP       = 4'd0;
  localparam logic [7:0] REPEAT_FOREVER = 8'hFF;
  localparam pins_t      PINS_OFF       = '1;

  typedef enum logic [2:0] {
    PH_ON    = 3'b001,
    PH_OFF   = 3'b010,
    PH_DELAY = 3'b100
  } phase_e;

  typedef struct packed {
    logic       opcode;
    logic [3:0] pattern_select;
  } lbps_in_t;

  typedef struct packed {
    logic red_pin;
    logic green_pin;
    logic blue_pin;
    logic running;
  } lbps_out_t;

  // active low: clear a bit to light it
  function automatic pins_t light_on(pins_t pins, logic [7:0] cm);
    pins_t res;
    res = pins;
    case (cm[4:3])
      MODE_ALL: res = pins & ~cm[2:0];
      MODE_EDGE: begin
        if (cm[0])      res = pins & 3'b110;
        else if (cm[1]) res = pins & 3'b101;
        else if (cm[2]) res = pins & 3'b011;
      end
      default: res = pins;
    endcase
    return res;
  endfunction

  function automatic pins_t light_off(pins_t pins, logic [7:0] cm);
    pins_t res;
    res = pins;
    case (cm[4:3])
      MODE_ALL: res = pins | cm[2:0];
      MODE_EDGE: begin
        if (cm[2])      res = pins | 3'b100;
        else if (cm[1]) res = pins | 3'b010;
        else if (cm[0]) res = pins | 3'b001;
      end
      default: res = pins;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/lbps_core.sv
`default_nettype none

module lbps_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire lbps_pkg::pat_idx_t  cfg_idx_i,
  input  wire lbps_pkg::pat_word_t cfg_data_i,
  input  wire logic                step_i,
  input  wire lbps_pkg::lbps_in_t  item_i,
  output lbps_pkg::lbps_out_t      res_o
);
  import lbps_pkg::*;

  pat_word_t  pat_q [NumPatterns];
  logic       active_q, active_d;
  phase_e     phase_q, phase_d;
  logic       pend_on_q, pend_on_d;
  logic       pend_off_q, pend_off_d;
  logic [7:0] tick_q, tick_d;
  logic [7:0] rep_q, rep_d;
  logic [3:0] cur_q, cur_d;
  pins_t      pins_q, pins_d;

  pat_word_t  word;
  logic [7:0] cm, on_len, off_len, rep_len, dly_len;
  logic [3:0] cur_m1;

  assign cur_m1  = cur_q - 4'd1;
  assign word    = pat_q[cur_m1[PatIdxW-1:0]];
  assign cm      = word[7:0];
  assign on_len  = word[15:8];
  assign off_len = word[23:16];
  assign rep_len = word[31:24];
  assign dly_len = word[39:32];

  always_comb begin
    active_d   = active_q;
    phase_d    = phase_q;
    pend_on_d  = pend_on_q;
    pend_off_d = pend_off_q;
    tick_d     = tick_q;
    rep_d      = rep_q;
    cur_d      = cur_q;
    pins_d     = pins_q;
    if (step_i) begin
      if (item_i.opcode == OP_TICK) begin
        if (active_q) begin
          // finished phases fall through within one beat
          if (phase_d == PH_ON) begin
            if (pend_on_d) begin
              pins_d    = light_on(pins_d, cm);
              pend_on_d = 1'b0;
            end
            tick_d = tick_d + 8'd1;
            if (tick_d >= on_len) begin
              tick_d     = '0;
              phase_d    = PH_OFF;
              pend_off_d = 1'b1;
            end
          end
          if (phase_d == PH_OFF) begin
            if (pend_off_d) begin
              pins_d     = light_off(pins_d, cm);
              pend_off_d = 1'b0;
            end
            tick_d = tick_d + 8'd1;
            if (tick_d >= off_len) begin
              tick_d  = '0;
              phase_d = PH_DELAY;
            end
          end
          if (phase_d == PH_DELAY) begin
            tick_d = tick_d + 8'd1;
            if (tick_d >= dly_len) begin
              tick_d = '0;
              rep_d  = rep_d + 8'd1;
              if (rep_d >= rep_len && rep_len != REPEAT_FOREVER) begin
                cur_d      = '0;
                rep_d      = '0;
                active_d   = 1'b0;
                pend_on_d  = 1'b0;
                pend_off_d = 1'b0;
                pins_d     = PINS_OFF;
              end else begin
                phase_d   = PH_ON;
                pend_on_d = 1'b1;
              end
            end
          end
        end
      end else if (item_i.pattern_select == SEL_STOP) begin
        cur_d      = '0;
        rep_d      = '0;
        tick_d     = '0;
        active_d   = 1'b0;
        pend_on_d  = 1'b0;
        pend_off_d = 1'b0;
        pins_d     = PINS_OFF;
      end else if (item_i.pattern_select <= 4'(NumPatterns)) begin
        cur_d   = item_i.pattern_select;
        phase_d = PH_ON;
        if (!active_q) begin
          active_d  = 1'b1;
          pend_on_d = 1'b1;
        end else begin
          // switch pattern, pins keep their levels
          rep_d      = '0;
          tick_d     = '0;
          pend_on_d  = 1'b0;
          pend_off_d = 1'b0;
        end
      end
    end
    res_o.red_pin   = pins_d[0];
    res_o.green_pin = pins_d[1];
    res_o.blue_pin  = pins_d[2];
    res_o.running   = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= PatDefault;
    end else if (cfg_we_i) begin
      pat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      phase_q    <= PH_ON;
      pend_on_q  <= 1'b0;
      pend_off_q <= 1'b0;
      tick_q     <= '0;
      rep_q      <= '0;
      cur_q      <= '0;
      pins_q     <= PINS_OFF;
    end else begin
      active_q   <= active_d;
      phase_q    <= phase_d;
      pend_on_q  <= pend_on_d;
      pend_off_q <= pend_off_d;
      tick_q     <= tick_d;
      rep_q      <= rep_d;
      cur_q      <= cur_d;
      pins_q     <= pins_d;
    end
  end

endmodule

`default_nettype wire

>>> design/lbps_out_buf.sv
`default_nettype none

// two-entry result buffer; slot 0 is the head
module lbps_out_buf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire lbps_pkg::lbps_out_t push_data_i,
  output logic                     full_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output lbps_pkg::lbps_out_t      out_data_o
);
  import lbps_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  lbps_out_t  slot0_q, slot0_d;
  lbps_out_t  slot1_q, slot1_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign out_data_o  = slot0_q;

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    case (cnt_q)
      2'd0: begin
        if (push_i) begin
          slot0_d = push_data_i;
          cnt_d   = 2'd1;
        end
      end
      2'd1: begin
        if (push_i && pop) begin
          slot0_d = push_data_i;
        end else if (push_i) begin
          slot1_d = push_data_i;
          cnt_d   = 2'd2;
        end else if (pop) begin
          cnt_d = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          slot0_d = slot1_q;
          cnt_d   = 2'd1;
        end
      end
      default: cnt_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

`default_nettype wire

>>> design/led_blink_pattern_sequencer.sv
// LED blink pattern sequencer.
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat is either a tick
// or a pattern select. Output channel (out_valid_o/out_ready_i/out_data_o):
// exactly one beat per input beat, carrying the active-low red/green/blue
// pin levels and the running flag after that item's update.
// An item's result is offered on the cycle after it is accepted if the
// output buffer was empty. Throughput: one item per cycle while in_ready_o
// is high; the whole state update runs in the accept cycle and its result
// lands in a two-entry output buffer. When the receiver stalls, the buffer
// holds up to two results; in_ready_o drops only while both entries are
// occupied and rises again on the first output beat taken.
// Pattern registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// (index 0 = pattern 1); write only while no item is in flight.
// Reset: pattern registers return to their default words, the sequencer is
// stopped, all pins read 1 (LEDs off) and the output buffer is empty.
`default_nettype none

module led_blink_pattern_sequencer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire lbps_pkg::pat_idx_t  cfg_idx_i,
  input  wire lbps_pkg::pat_word_t cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire lbps_pkg::lbps_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output lbps_pkg::lbps_out_t      out_data_o
);
  import lbps_pkg::*;

  logic      in_acc;
  logic      buf_full;
  lbps_out_t res;

  assign in_ready_o = !buf_full;
  assign in_acc     = in_valid_i && in_ready_o;

  lbps_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (in_acc),
    .item_i     (in_data_i),
    .res_o      (res)
  );

  lbps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // a stopped sequencer always shows all LEDs dark
  a_stopped_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.running |->
      out_data_o.red_pin && out_data_o.green_pin && out_data_o.blue_pin)
    else $error("stopped sequencer with a lit pin");

  // a stop command clears the running flag in its own result
  a_stop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.opcode == OP_SELECT && in_data_i.pattern_select == SEL_STOP
      |-> !res.running)
    else $error("stop command left sequencer running");

  // an accepted beat into an empty buffer is offered on the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o |=> out_valid_o && out_data_o == $past(res))
    else $error("result not offered one cycle after accept");

endmodule

`default_nettype wire
